// ===== hw/rtl/wbss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbss_pkg
// shared constants, register codes and control types of the wildcard byte
// signature scanner
// ----------------------------------------------------------------------------
package wbss_pkg;

  // defaults for the top level parameters
  localparam int MAX_PATTERN_BYTES_DEF = 32;
  localparam int ADDRESS_BITS_DEF      = 32;

  // fixed field widths
  localparam int DATA_W        = 8;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int PATTERN_LEN_W = 6;
  localparam int SCAN_ADDR_W   = 32;
  localparam int MATCH_ADDR_W  = 32;

  // register storage for up to 32 pattern bytes and their nibble care bits
  localparam int PATTERN_BYTES_STORED = 32;
  localparam int PATTERN_FLAT_W       = PATTERN_BYTES_STORED * DATA_W;
  localparam int CARE_W               = 2 * PATTERN_BYTES_STORED;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_WORD_0 = 3'd0,
    REG_PATTERN_WORD_1 = 3'd1,
    REG_PATTERN_WORD_2 = 3'd2,
    REG_PATTERN_WORD_3 = 3'd3,
    REG_NIBBLE_CARE    = 3'd4,
    REG_PATTERN_LENGTH = 3'd5,
    REG_SCAN_START     = 3'd6,
    REG_SCAN_END       = 3'd7
  } cfg_reg_t;

  // per-beat control handed to the cell chain
  typedef struct packed {
    logic upd;      // shift the partial match vector
    logic restart;  // region restarts on this beat, vector starts from zero
  } wbss_step_t;

endpackage

// ===== hw/rtl/wbss_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbss_cell
// one pattern byte position: nibble-masked compare and one bit of the
// shift-and partial match vector
// ----------------------------------------------------------------------------
module wbss_cell
  import wbss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              upd,
  input  logic [DATA_W-1:0] data_byte,
  input  logic [DATA_W-1:0] pat_byte,
  input  logic [1:0]        care,
  input  logic              enable,
  input  logic              carry_in,
  output logic              hit,
  output logic              match_r
);

  logic [DATA_W-1:0] cmp_mask;
  logic              byte_eq;

  assign cmp_mask = {{(DATA_W/2){care[1]}}, {(DATA_W/2){care[0]}}};
  assign byte_eq  = ((pat_byte ^ data_byte) & cmp_mask) == '0;
  assign hit      = carry_in & enable & byte_eq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (upd) begin
      match_r <= hit;
    end
  end

endmodule

// ===== hw/rtl/wbss_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbss_chain
// row of match cells, each handing its vector bit to the next one
// ----------------------------------------------------------------------------
module wbss_chain
  import wbss_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
  localparam int LIDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  wbss_step_t                step,
  input  logic [DATA_W-1:0]         data_byte,
  input  logic [PATTERN_FLAT_W-1:0] pattern,
  input  logic [CARE_W-1:0]         care,
  input  logic [LIDX_W-1:0]         len_idx,
  output logic                      full_hit
);

  logic [MAX_PATTERN_BYTES-1:0] vec;
  logic [MAX_PATTERN_BYTES-1:0] hit;
  logic [MAX_PATTERN_BYTES-1:0] carry;

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    // first cell always starts a fresh partial match
    if (k == 0) begin : g_head
      assign carry[k] = 1'b1;
    end else begin : g_link
      assign carry[k] = vec[k-1] & ~step.restart;
    end

    wbss_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .upd       (step.upd),
      .data_byte (data_byte),
      .pat_byte  (pattern[DATA_W*k +: DATA_W]),
      .care      (care[2*k +: 2]),
      .enable    (LIDX_W'(k) <= len_idx),
      .carry_in  (carry[k]),
      .hit       (hit[k]),
      .match_r   (vec[k])
    );
  end

  // full match when the cell of the last used byte hits
  assign full_hit = hit[len_idx];

endmodule

// ===== hw/rtl/wildcard_byte_signature_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scan
// byte stream scanner for a nibble-wildcard signature of up to 32 bytes
// ----------------------------------------------------------------------------
// usage
//  - cfg channel: index/data write beats, always ready; pattern words, nibble
//    care mask, pattern length and scan window are written while idle
//  - in channel: one data byte per beat; first_of_region marks the byte at
//    scan_start and restarts the scan, bytes before the first mark or after
//    a result are dropped without effect
//  - out channel: one beat per region, found with the address of the first
//    matching byte, or not-found (address 0) when the region's last byte goes
//    by without a match or the region is empty
//  - throughput is one byte per cycle while in_stall is low: the cell chain
//    updates its partial match vector in the cycle a byte is taken
//  - the result beat is registered and valid the cycle after the byte that caused it
//  - in_stall is raised only while a result sits in the output register and
//    the receiver stalls it, so bytes keep flowing while out is free
//  - reset (synchronous, rst_n low) clears the vector, loads the register
//    defaults (length 1, all else zero) and leaves the scan idle until the
//    next first_of_region mark
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scan
  import wbss_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
  parameter int ADDRESS_BITS      = ADDRESS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // byte input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [DATA_W-1:0]       in_data_byte,
  input  logic                    in_first_of_region,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_found,
  output logic [MATCH_ADDR_W-1:0] out_match_address
);

  localparam int LIDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  // wide enough for either address width plus one
  localparam int EXT_W  = ((ADDRESS_BITS > SCAN_ADDR_W) ? ADDRESS_BITS : SCAN_ADDR_W) + 1;

  // configuration registers
  logic [CFG_DATA_W-1:0]    pat_word_r [4];
  logic [CARE_W-1:0]        care_r;
  logic [PATTERN_LEN_W-1:0] len_r;
  logic [SCAN_ADDR_W-1:0]   start_r;
  logic [SCAN_ADDR_W-1:0]   end_r;

  // scan state
  logic [ADDRESS_BITS-1:0]  cur_r, cur_nxt;
  logic                     fin_r, fin_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_found_r, out_found_nxt;
  logic [MATCH_ADDR_W-1:0]  out_addr_r, out_addr_nxt;

  logic                     accept;
  logic                     fin_eff;
  logic [ADDRESS_BITS-1:0]  cur_eff;
  logic [ADDRESS_BITS-1:0]  cur_inc;
  logic [EXT_W-1:0]         start_ext, cur_ext, end_ext, match_ext;
  logic                     live, empty, last, full_hit, res_valid;
  logic [LIDX_W-1:0]        len_idx;
  wbss_step_t               step;
  logic [PATTERN_FLAT_W-1:0] pattern_flat;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_word_r[0] <= '0;
      pat_word_r[1] <= '0;
      pat_word_r[2] <= '0;
      pat_word_r[3] <= '0;
      care_r        <= '0;
      len_r         <= PATTERN_LEN_W'(1);
      start_r       <= '0;
      end_r         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_WORD_0: pat_word_r[0] <= cfg_data;
        REG_PATTERN_WORD_1: pat_word_r[1] <= cfg_data;
        REG_PATTERN_WORD_2: pat_word_r[2] <= cfg_data;
        REG_PATTERN_WORD_3: pat_word_r[3] <= cfg_data;
        REG_NIBBLE_CARE:    care_r        <= cfg_data[CARE_W-1:0];
        REG_PATTERN_LENGTH: len_r         <= cfg_data[PATTERN_LEN_W-1:0];
        REG_SCAN_START:     start_r       <= cfg_data[SCAN_ADDR_W-1:0];
        REG_SCAN_END:       end_r         <= cfg_data[SCAN_ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign pattern_flat = {pat_word_r[3], pat_word_r[2], pat_word_r[1], pat_word_r[0]};

  // length in use, clamped to 1..MAX_PATTERN_BYTES, as the index of its last byte
  always_comb begin
    if (len_r == '0) begin
      len_idx = '0;
    end else if (len_r > PATTERN_LEN_W'(MAX_PATTERN_BYTES)) begin
      len_idx = LIDX_W'(MAX_PATTERN_BYTES - 1);
    end else begin
      len_idx = LIDX_W'(len_r - PATTERN_LEN_W'(1));
    end
  end

  // ------------------------------------------------------------- handshake
  // only a blocked result holds off new bytes
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // ------------------------------------------------------------ scan step
  // a marked byte restarts the region before it is looked at
  assign start_ext = EXT_W'(start_r);
  assign fin_eff   = in_first_of_region ? 1'b0 : fin_r;
  assign cur_eff   = in_first_of_region ? start_ext[ADDRESS_BITS-1:0] : cur_r;
  assign cur_inc   = cur_eff + ADDRESS_BITS'(1);
  assign cur_ext   = EXT_W'(cur_eff);
  assign end_ext   = EXT_W'(end_r);

  assign live  = accept & ~fin_eff;
  // window already passed or empty: report not-found without matching
  assign empty = cur_ext >= end_ext;
  // last byte of the region, seen with and without address wrap
  assign last  = (EXT_W'(cur_inc) == end_ext) ||
                 ((cur_ext + EXT_W'(1)) == end_ext);

  assign step.upd     = live & ~empty;
  assign step.restart = in_first_of_region;

  wbss_chain #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_data_byte),
    .pattern   (pattern_flat),
    .care      (care_r),
    .len_idx   (len_idx),
    .full_hit  (full_hit)
  );

  // start of the match lies len-1 bytes back
  assign match_ext = EXT_W'(ADDRESS_BITS'(cur_eff - ADDRESS_BITS'(len_idx)));
  assign res_valid = live & (empty | full_hit | last);

  always_comb begin
    cur_nxt       = cur_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;
    if (accept) begin
      fin_nxt = fin_eff | res_valid;
      cur_nxt = (live && !res_valid) ? cur_inc : cur_eff;
    end
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = ~empty & full_hit;
      out_addr_nxt  = (~empty & full_hit) ? match_ext[MATCH_ADDR_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      fin_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, held while the beat is stalled
  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_addr_r  <= out_addr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_address = out_addr_r;

endmodule

// ===== sim/wildcard_byte_signature_scan_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scan_tb
// self-checking bench for the nibble-wildcard signature scanner: a shift-and
// predictor inside a small scoreboard class follows every accepted byte beat,
// and each result beat is checked against the oldest predicted outcome while
// regions with planted signatures stream through under random back-pressure
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scan_tb;
  import wbss_pkg::*;

  localparam int RANDOM_BYTES = 950;      // byte beats wanted from the random part
  localparam int QUIET_TAIL   = 150;      // last byte beats run with no idling
  localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
  localparam int TIMEOUT_NS   = 5000000;

  // one predicted outcome of a region
  typedef struct packed {
    logic                    found;
    logic [MATCH_ADDR_W-1:0] addr;
  } scan_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the registers and the scan state, shift-and match
  // --------------------------------------------------------------------------
  class signature_scoreboard;
    logic [PATTERN_FLAT_W-1:0] pattern;
    logic [CARE_W-1:0]         care;
    logic [PATTERN_LEN_W-1:0]  len_reg;
    logic [SCAN_ADDR_W-1:0]    region_start;
    logic [SCAN_ADDR_W-1:0]    region_end;
    logic [31:0]               match_vec;
    logic [SCAN_ADDR_W-1:0]    cur_addr;
    logic                      finished;
    scan_result_t              expected_hits[$];
    int                        errors;
    int                        in_beats;
    int                        live_bytes;
    int                        found_seen;
    int                        missing_seen;

    function new();
      pattern      = '0;
      care         = '0;
      len_reg      = 1;
      region_start = '0;
      region_end   = '0;
      match_vec    = '0;
      cur_addr     = '0;
      finished     = 1'b1;
      errors       = 0;
      in_beats     = 0;
      live_bytes   = 0;
      found_seen   = 0;
      missing_seen = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PATTERN_WORD_0: pattern[0   +: 64] = val;
        REG_PATTERN_WORD_1: pattern[64  +: 64] = val;
        REG_PATTERN_WORD_2: pattern[128 +: 64] = val;
        REG_PATTERN_WORD_3: pattern[192 +: 64] = val;
        REG_NIBBLE_CARE:    care = val;
        REG_PATTERN_LENGTH: len_reg = val[PATTERN_LEN_W-1:0];
        REG_SCAN_START:     region_start = val[SCAN_ADDR_W-1:0];
        REG_SCAN_END:       region_end = val[SCAN_ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    // length zero acts as one, anything above 32 as 32
    function int unsigned used_len();
      if (len_reg == 0) return 1;
      if (len_reg > 32) return 32;
      return 32'(len_reg);
    endfunction

    function void take_byte(logic [DATA_W-1:0] b, logic first);
      int unsigned  n;
      int           k;
      logic [31:0]  eq;
      logic [7:0]   pb;
      logic [7:0]   m;
      scan_result_t r;
      n = used_len();
      in_beats++;
      if (first) begin
        match_vec = '0;
        cur_addr  = region_start;
        finished  = 1'b0;
      end
      if (finished) return;
      live_bytes++;
      // empty region: not-found at once, nothing compared
      if (cur_addr >= region_end) begin
        finished = 1'b1;
        r.found  = 1'b0;
        r.addr   = '0;
        expected_hits.push_back(r);
        return;
      end
      eq = '0;
      for (k = 0; k < n; k++) begin
        pb    = pattern[8*k +: 8];
        m     = {{4{care[2*k+1]}}, {4{care[2*k]}}};
        eq[k] = ((pb ^ b) & m) == 8'h00;
      end
      match_vec = ((match_vec << 1) | 32'd1) & eq;
      if (match_vec[n-1]) begin
        finished = 1'b1;
        r.found  = 1'b1;
        r.addr   = cur_addr - (n - 1);
        expected_hits.push_back(r);
      end else if (cur_addr + 32'd1 == region_end) begin
        finished = 1'b1;
        r.found  = 1'b0;
        r.addr   = '0;
        expected_hits.push_back(r);
      end else begin
        cur_addr = cur_addr + 32'd1;
      end
    endfunction

    function void check_result(logic found, logic [MATCH_ADDR_W-1:0] addr);
      scan_result_t want;
      if (expected_hits.size() == 0) begin
        $error("unexpected result beat: found %0d match_address 0x%08h", found, addr);
        errors++;
        return;
      end
      want = expected_hits.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, found);
        errors++;
      end
      if (addr !== want.addr) begin
        $error("match_address: expected 0x%08h, actual 0x%08h", want.addr, addr);
        errors++;
      end
      if (want.found) found_seen++;
      else missing_seen++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, ports, instance
  // --------------------------------------------------------------------------
  logic                    clk                = 1'b0;
  logic                    rst_n              = 1'b0;
  logic                    cfg_valid          = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index          = '0;
  logic [CFG_DATA_W-1:0]   cfg_data           = '0;
  logic                    in_valid           = 1'b0;
  logic                    in_stall;
  logic [DATA_W-1:0]       in_data_byte       = '0;
  logic                    in_first_of_region = 1'b0;
  logic                    out_valid;
  logic                    out_stall          = 1'b0;
  logic                    out_found;
  logic [MATCH_ADDR_W-1:0] out_match_address;

  signature_scoreboard sb;
  bit quiet        = 1'b0;   // no idling on either side
  bit hold_pending = 1'b0;   // asks the receiver for one long hold-off
  int phase_count  = 0;
  int directed_beats;

  always #6 clk = ~clk;

  wildcard_byte_signature_scan dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_first_of_region (in_first_of_region),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_found          (out_found),
    .out_match_address  (out_match_address)
  );

  // --------------------------------------------------------------------------
  // monitor: results are checked before the same edge's byte is noted, a
  // result can never come from the byte taken on its own edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_found, out_match_address);
      if (in_valid && !in_stall) sb.take_byte(in_data_byte, in_first_of_region);
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stall bursts, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // one byte beat, with an occasional gap before it
  task automatic send_byte(logic [DATA_W-1:0] b, logic first);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data_byte       <= b;
    in_first_of_region <= first;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // valid stays high across a batch of writes, the caller lowers it
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic program_scan(logic [PATTERN_FLAT_W-1:0] pat, logic [CARE_W-1:0] care,
                              logic [CFG_DATA_W-1:0] len, logic [SCAN_ADDR_W-1:0] start,
                              logic [SCAN_ADDR_W-1:0] stop);
    write_reg(REG_PATTERN_WORD_0, pat[0   +: 64]);
    write_reg(REG_PATTERN_WORD_1, pat[64  +: 64]);
    write_reg(REG_PATTERN_WORD_2, pat[128 +: 64]);
    write_reg(REG_PATTERN_WORD_3, pat[192 +: 64]);
    write_reg(REG_NIBBLE_CARE, care);
    write_reg(REG_PATTERN_LENGTH, len);
    write_reg(REG_SCAN_START, {32'd0, start});
    write_reg(REG_SCAN_END, {32'd0, stop});
    cfg_valid <= 1'b0;
  endtask

  // sender pauses while the registered result drains, then until every predicted
  // outcome has arrived
  task automatic settle();
    in_valid <= 1'b0;
    repeat (4) @(posedge clk);
    while (sb.expected_hits.size() != 0) @(posedge clk);
  endtask

  // one region: mark on the first byte, random body with the signature
  // planted most of the time, the odd restart and some trailing bytes
  task automatic send_region(logic [PATTERN_FLAT_W-1:0] pat, logic [CARE_W-1:0] care,
                             int unsigned n, int unsigned span);
    logic [DATA_W-1:0] body[$];
    logic [7:0]        m;
    int unsigned       at;
    int unsigned       k;
    int unsigned       tail;
    int                restart_at;
    // stray unmarked bytes while idle, dropped by the block
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom()), 1'b0);
    end
    for (k = 0; k < span; k++) body.push_back(8'($urandom()));
    if (span >= n && $urandom_range(0, 3) != 0) begin
      at = $urandom_range(0, span - n);
      for (k = 0; k < n; k++) begin
        m = {{4{care[2*k+1]}}, {4{care[2*k]}}};
        body[at+k] = (pat[8*k +: 8] & m) | (8'($urandom()) & ~m);
      end
      // near miss: one bit of the planted copy flipped
      if ($urandom_range(0, 4) == 0) begin
        k = $urandom_range(0, n - 1);
        body[at+k][$urandom_range(0, 7)] ^= 1'b1;
      end
    end
    restart_at = -1;
    if (span > 1 && $urandom_range(0, 7) == 0) restart_at = $urandom_range(1, span - 1);
    tail = $urandom_range(0, 3);
    for (k = 0; k < span + tail; k++) begin
      send_byte((k < span) ? body[k] : 8'($urandom()), (k == 0) || (k == restart_at));
    end
  endtask

  // one configuration and a handful of regions under it; the first few
  // phases force the register extremes
  task automatic run_phase(int idx);
    logic [PATTERN_FLAT_W-1:0] pat;
    logic [CARE_W-1:0]         care;
    logic [PATTERN_LEN_W-1:0]  len_reg;
    logic [SCAN_ADDR_W-1:0]    start;
    logic [SCAN_ADDR_W-1:0]    stop;
    int unsigned               n;
    int unsigned               span;
    int                        k;
    for (k = 0; k < 8; k++) pat[32*k +: 32] = $urandom();
    case ($urandom_range(0, 4))
      0:       care = '1;
      1:       care = '0;
      2:       care = {$urandom(), $urandom()};
      default: care = {$urandom(), $urandom()} | {$urandom(), $urandom()};
    endcase
    if ($urandom_range(0, 1) == 0) len_reg = PATTERN_LEN_W'($urandom_range(1, 4));
    else len_reg = PATTERN_LEN_W'($urandom_range(1, 32));
    case (idx)
      0: len_reg = 0;                                // used as one
      1: begin len_reg = 63; care = '1; end          // clipped to 32
      2: len_reg = 1;                                // long hold-off phase
      3: begin len_reg = 32; care = '0; end          // everything wild
      4: pat = '0;
      5: begin pat = '1; care = '1; end
      default: ;
    endcase
    n = (len_reg == 0) ? 1 : ((len_reg > 32) ? 32 : len_reg);
    span = n + $urandom_range(0, 10);
    if ($urandom_range(0, 7) == 0) span = $urandom_range(1, n);
    if (idx == 2) span = $urandom_range(1, 3);
    case ($urandom_range(0, 5))
      0:       start = '0;
      1:       start = 32'hffff_ffff - span;         // region ends at the top address
      2:       start = 32'hffff_ffff;                // end wraps below start
      default: start = $urandom();
    endcase
    stop = start + span;
    if ($urandom_range(0, 11) == 0) stop = start - $urandom_range(0, 3);
    program_scan(pat, care, CFG_DATA_W'(len_reg), start, stop);
    // fill the block against a stalled receiver
    if (idx == 2) hold_pending = 1'b1;
    repeat ($urandom_range(4, 10)) send_region(pat, care, n, span);
    settle();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle after reset: an unmarked byte is dropped
    send_byte(8'h5a, 1'b0);
    // reset registers describe an empty region: the mark alone gives not-found
    send_byte(8'h00, 1'b1);
    settle();

    // two-byte signature a5 3c over a four-byte region at 0x100
    program_scan(256'h3ca5, 64'h0f, 64'd2, 32'h0000_0100, 32'h0000_0104);
    // match at the region start, the byte after the result is dropped
    send_byte(8'ha5, 1'b1);
    send_byte(8'h3c, 1'b0);
    send_byte(8'hff, 1'b0);
    // overlapping start, match completes on the region's last byte
    send_byte(8'h00, 1'b1);
    send_byte(8'ha5, 1'b0);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h3c, 1'b0);
    // last byte passes with no match
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // second mark in mid-region restarts the scan
    send_byte(8'ha5, 1'b1);
    send_byte(8'ha5, 1'b1);
    send_byte(8'h3c, 1'b0);
    settle();

    // length zero acts as one, low nibble wild, region just under the top
    program_scan(256'ha0, 64'h02, 64'd0, 32'hffff_fff0, 32'hffff_ffff);
    send_byte(8'h15, 1'b1);
    send_byte(8'haf, 1'b0);
    settle();

    directed_beats = sb.in_beats;
    while (sb.in_beats - directed_beats < RANDOM_BYTES) begin
      quiet = (sb.in_beats - directed_beats >= RANDOM_BYTES - QUIET_TAIL);
      run_phase(phase_count);
      phase_count++;
    end

    settle();
    repeat (8) @(posedge clk);
    $display("scanned %0d live bytes of %0d byte beats over %0d random configurations",
             sb.live_bytes, sb.in_beats, phase_count);
    $display("checked %0d found and %0d not-found results", sb.found_seen, sb.missing_seen);
    if (sb.errors == 0 && sb.expected_hits.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/wbss_pkg.sv
hw/rtl/wbss_cell.sv
hw/rtl/wbss_chain.sv
hw/rtl/wildcard_byte_signature_scan.sv
sim/wildcard_byte_signature_scan_tb.sv
